@@ hdl/vsd_pkg.sv @@
// Shared types and constants for the voted strip detector.
// Used by vsd_ctrl, vsd_dp and voted_strip_detector; depends on nothing.
package vsd_pkg;

   localparam int Sensors   = 3;
   localparam int IdW       = 2;
   localparam int TimeW     = 64;
   localparam int SpeedW    = 16;
   localparam int NumW      = 40;
   localparam int WinW      = 32;
   localparam int CountW    = 16;
   localparam int DivW      = SpeedW + 1;
   localparam int DivSteps  = NumW;
   localparam int StepW     = $clog2(DivSteps);
   localparam int CsrAddrW  = 2;
   localparam int CsrDataW  = NumW;
   localparam int ReqDataW  = 88;
   localparam int RspDataW  = 152;

   localparam logic [NumW-1:0] DelayNumReset = NumW'(20000000);
   localparam logic [WinW-1:0] VoteWinReset  = WinW'(200000);
   localparam logic [WinW-1:0] VoteRstReset  = WinW'(3000000);

   typedef enum logic [CsrAddrW-1:0] {
      CSR_DELAY_NUM = 2'd0,
      CSR_VOTE_WIN  = 2'd1,
      CSR_VOTE_RST  = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_addr_type;

   // which sensor time to fetch: own, next, or the one after next
   typedef enum logic [1:0] {
      RD_OWN  = 2'd0,
      RD_NEXT = 2'd1,
      RD_LAST = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       lock;
      logic       acc;
      logic       near1;
      logic       near2;
      logic       vote;
      logic       out_load;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic bad_id;
      logic out_free;
   } status_type;

   // sensor index offset by 0, 1 or 2, modulo three
   function automatic logic [IdW-1:0] sensor_offset(input logic [IdW-1:0] id,
                                                     input rd_sel_type sel);
      logic [IdW-1:0] r;
      r = id;
      case (sel)
         RD_OWN:  r = id;
         RD_NEXT: r = (id == IdW'(Sensors-1)) ? '0 : id + 1'b1;
         RD_LAST: r = (id == '0) ? IdW'(Sensors-1) : id - 1'b1;
         default: r = id;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/vsd_ctrl.sv @@
// Sequencer for the voted strip detector: steps divider, lockout, vote, output.
// Depends on vsd_pkg; drives vsd_dp through cmd_type and reads status_type.
module vsd_ctrl
   import vsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_LOCK, S_ACC, S_NEAR1, S_NEAR2, S_VOTE, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = in_valid;
            step_in  = '0;
            if (in_valid) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.rd_sel = RD_OWN;
            if (status.bad_id) begin
               state_in = S_DONE;
            end else begin
               cmd.div_step = 1'b1;
               step_in      = step_ff + 1'b1;
               if (step_ff == StepW'(DivSteps-1)) state_in = S_LOCK;
            end
         end
         S_LOCK: begin
            cmd.lock   = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc    = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = S_NEAR1;
         end
         S_NEAR1: begin
            cmd.near1 = 1'b1;
            state_in  = S_NEAR2;
         end
         S_NEAR2: begin
            cmd.near2 = 1'b1;
            state_in  = S_VOTE;
         end
         S_VOTE: begin
            cmd.vote = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign in_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ hdl/vsd_dp.sv @@
// Datapath: settings, sensor time store, restoring divider, compares, strip state
// and the result register. Depends on vsd_pkg; commanded by vsd_ctrl.
module vsd_dp
   import vsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_wen,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [IdW-1:0]      in_id,
   input  logic [TimeW-1:0]    in_time,
   input  logic [SpeedW-1:0]   in_speed,
   input  logic                out_ready,
   output logic                out_valid,
   output logic                out_accepted,
   output logic                out_vote_pass,
   output logic [CountW-1:0]   out_count,
   output logic [TimeW-1:0]    out_last,
   output logic [TimeW-1:0]    out_prev
);

   logic [NumW-1:0]  delay_num_ff;
   logic [WinW-1:0]  vote_win_ff, vote_rst_ff;

   logic [TimeW-1:0] times_mem [Sensors];
   logic [Sensors-1:0] times_vld_ff;
   logic [TimeW-1:0] rdata_ff;
   logic [IdW-1:0]   rd_addr;

   logic [IdW-1:0]   id_ff;
   logic [TimeW-1:0] t_ff;
   logic [DivW-1:0]  divisor_ff, rem_ff, rem_in;
   logic [NumW-1:0]  quo_ff;
   logic [DivW:0]    trial;

   logic [TimeW:0]   lock_sub;
   logic [TimeW-1:0] diff_ff, d_ff, thr_ff;
   logic             lt_ff, acc_ff, near_ff, pass_ff, near_now;

   logic [TimeW-1:0]  strip_ff, prior_ff;
   logic [CountW-1:0] count_ff;
   logic              out_valid_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_num_ff <= DelayNumReset;
         vote_win_ff  <= VoteWinReset;
         vote_rst_ff  <= VoteRstReset;
      end else if (csr_wen) begin
         case (csr_addr_type'(csr_addr))
            CSR_DELAY_NUM: delay_num_ff <= csr_wdata;
            CSR_VOTE_WIN:  vote_win_ff  <= csr_wdata[WinW-1:0];
            CSR_VOTE_RST:  vote_rst_ff  <= csr_wdata[WinW-1:0];
            default: ;
         endcase
      end
   end

   // sensor time store, one registered read a cycle; unwritten entries read as zero
   assign rd_addr = sensor_offset(id_ff, cmd.rd_sel);

   always_ff @(posedge clock) begin
      rdata_ff <= times_vld_ff[rd_addr] ? times_mem[rd_addr] : '0;
      if (cmd.vote && acc_ff) times_mem[id_ff] <= t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) times_vld_ff <= '0;
      else if (cmd.vote && acc_ff) times_vld_ff[id_ff] <= 1'b1;
   end

   // restoring divider: one quotient bit a step, numerator shifted through quo_ff
   assign trial  = {rem_ff, quo_ff[NumW-1]} - {1'b0, divisor_ff};
   assign rem_in = trial[DivW] ? {rem_ff[DivW-2:0], quo_ff[NumW-1]} : trial[DivW-1:0];

   assign lock_sub = {1'b0, t_ff} - {1'b0, rdata_ff};
   assign near_now = (d_ff <= {{(TimeW-WinW){1'b0}}, vote_win_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= in_id;
         t_ff       <= in_time;
         divisor_ff <= {1'b0, in_speed} + 1'b1;
         rem_ff     <= '0;
         quo_ff     <= delay_num_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NumW-2:0], ~trial[DivW]};
      end
      if (cmd.lock) begin
         diff_ff <= lock_sub[TimeW-1:0];
         lt_ff   <= lock_sub[TimeW];
      end
      if (cmd.acc)   d_ff <= t_ff - rdata_ff;
      if (cmd.near1) begin
         near_ff <= near_now;
         d_ff    <= t_ff - rdata_ff;
      end
      if (cmd.near2) begin
         near_ff <= near_ff | near_now;
         thr_ff  <= strip_ff + {{(TimeW-WinW){1'b0}}, vote_rst_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 1'b0;
         pass_ff  <= 1'b0;
         strip_ff <= '0;
         prior_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.load) begin
            acc_ff  <= 1'b0;
            pass_ff <= 1'b0;
         end
         if (cmd.acc)
            acc_ff <= lt_ff | (diff_ff > {{(TimeW-NumW){1'b0}}, quo_ff});
         if (cmd.vote && acc_ff && near_ff && (t_ff > thr_ff)) begin
            pass_ff  <= 1'b1;
            prior_ff <= strip_ff;
            strip_ff <= t_ff;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (out_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_accepted  <= acc_ff;
         out_vote_pass <= pass_ff;
         out_count     <= count_ff;
         out_last      <= strip_ff;
         out_prev      <= prior_ff;
      end
   end

   assign out_valid       = out_valid_ff;
   assign status.bad_id   = (id_ff == IdW'(Sensors));
   assign status.out_free = ~out_valid_ff | out_ready;

endmodule

@@ hdl/voted_strip_detector.sv @@
// Voted strip detector: per-sensor lockout followed by a 2-of-3 vote and a strip count.
// Top level; instantiates vsd_ctrl and vsd_dp, uses vsd_pkg.
//
// Usage:
//   req_ channel: one edge event per item; req_tdata holds sensor_id, timestamp_us
//   and speed_tenths. rsp_ channel: one result item per event.
//   csr_ port: csr_wen writes csr_wdata to register csr_addr (0 delay numerator,
//   1 vote window, 2 vote reset time) on the same edge; write only while idle.
// Sequence: an item is processed one at a time. The accept edge captures it, then
//   the bit-serial lockout divider (delay_numerator / (speed+1)) runs, then the lock,
//   acc, near1, near2 and vote states do the 64-bit compares and state update, then
//   the done state loads the result register once it is free; only then is a new
//   item accepted. An event from sensor number three skips the divider and goes
//   straight to the done state.
// Reset: sensor times, strip times and count clear; registers take their defaults.
// Stall: a result waits in the output register while the next item is worked on;
//   that item's result holds the block until the register is taken.
module voted_strip_detector
   import vsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [1:0] sensor_id, [65:2] timestamp_us, [81:66] speed_tenths, [87:82] unused
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [0] accepted, [1] vote_pass, [17:2] strip_count, [81:18] last_strip_time,
   // [145:82] previous_strip_time, [151:146] zero
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_wen,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cmd_type           cmd;
   status_type        status;
   logic              accepted, vote_pass;
   logic [CountW-1:0] strip_count;
   logic [TimeW-1:0]  last_time, prev_time;

   vsd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   vsd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .in_id         (req_tdata[IdW-1:0]),
      .in_time       (req_tdata[IdW+TimeW-1:IdW]),
      .in_speed      (req_tdata[IdW+TimeW+SpeedW-1:IdW+TimeW]),
      .out_ready     (rsp_tready),
      .out_valid     (rsp_tvalid),
      .out_accepted  (accepted),
      .out_vote_pass (vote_pass),
      .out_count     (strip_count),
      .out_last      (last_time),
      .out_prev      (prev_time)
   );

   assign rsp_tdata = {{(RspDataW-2-CountW-2*TimeW){1'b0}},
                       prev_time, last_time, strip_count, vote_pass, accepted};

   // a counted strip is always an accepted event
   a_pass_needs_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (accepted || !vote_pass))
      else $error("vote_pass without accepted");

   // one item in flight: no new accept right after one
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while busy");

   // result register only reloads when free
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten");

   // a strip is only counted from the vote step
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.vote) && !$past(reset) |-> $stable(u_dp.count_ff))
      else $error("count changed outside vote");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for voted_strip_detector: directed and random strip events on the req_ stream,
// every rsp_ item checked against an in-bench model of the lockout, vote and strip count.
// Depends on vsd_pkg and the voted_strip_detector RTL.
module tb;
   import vsd_pkg::*;

   typedef struct packed {
      logic [IdW-1:0]    sensor;
      logic [TimeW-1:0]  stamp;
      logic [SpeedW-1:0] speed;
   } strip_event_type;

   typedef struct {
      logic              accepted;
      logic              vote_pass;
      logic [CountW-1:0] count;
      logic [TimeW-1:0]  last_time;
      logic [TimeW-1:0]  prev_time;
   } strip_result_type;

   localparam logic [TimeW-1:0] TopTime = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_wen = 1'b0;
   csr_addr_type        csr_addr = CSR_DELAY_NUM;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // model copy of registers and state
   logic [NumW-1:0]   delay_num = DelayNumReset;
   logic [WinW-1:0]   vote_win = VoteWinReset;
   logic [WinW-1:0]   vote_rst = VoteRstReset;
   logic [TimeW-1:0]  sensor_time [Sensors] = '{default: '0};
   logic [TimeW-1:0]  last_strip = '0;
   logic [TimeW-1:0]  prior_strip = '0;
   logic [CountW-1:0] strip_count = '0;

   strip_event_type  pending_events [$];
   strip_result_type predicted_results [$];
   strip_event_type  in_flight;
   int               events_queued = 0;
   int               events_taken = 0;
   int               mismatches = 0;
   int               send_idle_pct = 20;
   int               recv_stall_pct = 46;

   voted_strip_detector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // lockout, then 2-of-3 vote; updates the model state
   function automatic strip_result_type count_strip(input strip_event_type ev);
      strip_result_type r;
      logic [TimeW-1:0] lockout, stored, gap, gap1, gap2, holdoff_end;
      int unsigned      id;
      r.accepted = 1'b0;
      r.vote_pass = 1'b0;
      id = ev.sensor;
      if (id < Sensors) begin
         lockout = TimeW'(delay_num) / (TimeW'(ev.speed) + 64'd1);
         stored = sensor_time[id];
         gap = ev.stamp - stored;
         if (gap > lockout || ev.stamp < stored) begin
            gap1 = ev.stamp - sensor_time[(id + 1) % Sensors];
            gap2 = ev.stamp - sensor_time[(id + 2) % Sensors];
            holdoff_end = last_strip + TimeW'(vote_rst);
            r.accepted = 1'b1;
            sensor_time[id] = ev.stamp;
            if ((gap1 <= TimeW'(vote_win) || gap2 <= TimeW'(vote_win)) &&
                ev.stamp > holdoff_end) begin
               r.vote_pass = 1'b1;
               prior_strip = last_strip;
               last_strip = ev.stamp;
               strip_count = strip_count + 1'b1;
            end
         end
      end
      r.count = strip_count;
      r.last_time = last_strip;
      r.prev_time = prior_strip;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void add_event(input logic [IdW-1:0] sensor,
                                     input logic [TimeW-1:0] stamp,
                                     input logic [SpeedW-1:0] speed);
      strip_event_type ev;
      ev.sensor = sensor;
      ev.stamp = stamp;
      ev.speed = speed;
      pending_events.push_back(ev);
      events_queued++;
   endfunction

   always @(posedge clock) begin : driver
      logic drive;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(count_strip(in_flight));
            events_taken++;
         end
         drive = req_tvalid && !req_tready;
         if (!drive && pending_events.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            in_flight = pending_events.pop_front();
            drive = 1'b1;
            req_tdata <= ReqDataW'({in_flight.speed, in_flight.stamp, in_flight.sensor});
         end
         req_tvalid <= drive;
      end
   end

   always @(posedge clock) begin : monitor
      strip_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %0h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = predicted_results.pop_front();
            check_field("accepted", want.accepted, rsp_tdata[0]);
            check_field("vote_pass", want.vote_pass, rsp_tdata[1]);
            check_field("strip_count", want.count, rsp_tdata[17:2]);
            check_field("last_strip_time", want.last_time, rsp_tdata[81:18]);
            check_field("previous_strip_time", want.prev_time, rsp_tdata[145:82]);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic write_csr(input csr_addr_type addr, input logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_DELAY_NUM: delay_num = value;
         CSR_VOTE_WIN:  vote_win = value[WinW-1:0];
         CSR_VOTE_RST:  vote_rst = value[WinW-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // junk in the unused top bits of the 32-bit registers
   task automatic set_registers(input logic [NumW-1:0] num, input logic [WinW-1:0] win,
                                input logic [WinW-1:0] hold);
      write_csr(CSR_DELAY_NUM, num);
      write_csr(CSR_VOTE_WIN, {8'($urandom), win});
      write_csr(CSR_VOTE_RST, {8'($urandom), hold});
   endtask

   task automatic drain();
      while (events_taken != events_queued || predicted_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // mostly whole strips (one to three sensors, some bounces), the rest noise
   task automatic run_strips(input int n_items, input logic [TimeW-1:0] start);
      logic [TimeW-1:0]  strip_clock, lockout, t;
      logic [SpeedW-1:0] spd;
      int                order [3];
      int                fired, k, target;
      target = events_queued + n_items;
      strip_clock = start;
      while (events_queued < target) begin
         spd = SpeedW'($urandom);
         if ($urandom_range(0, 99) < 70) begin
            lockout = TimeW'(delay_num) / (TimeW'(spd) + 64'd1);
            strip_clock = strip_clock + lockout + TimeW'(vote_rst) + TimeW'(vote_win) +
                          TimeW'($urandom_range(1, 2000000));
            order[0] = $urandom_range(0, 2);
            order[1] = (order[0] + $urandom_range(1, 2)) % Sensors;
            order[2] = 3 - order[0] - order[1];
            fired = ($urandom_range(0, 9) < 2) ? 1 : $urandom_range(2, 3);
            for (k = 0; k < fired; k++) begin
               t = strip_clock;
               if (k > 0) begin
                  if ($urandom_range(0, 7) == 0)
                     t = t + TimeW'(vote_win) + TimeW'($urandom_range(1, 1000));
                  else
                     t = t + TimeW'($urandom_range(0, vote_win));
               end
               add_event(IdW'(order[k]), t, spd);
               if ($urandom_range(0, 3) == 0)
                  add_event(IdW'(order[k]), t + rand64() % (lockout + 64'd1), spd);
            end
         end else begin
            case ($urandom_range(0, 2))
               0: t = rand64();
               1: t = strip_clock + TimeW'($urandom_range(0, 1000000));
               default: t = strip_clock - TimeW'($urandom);
            endcase
            add_event(IdW'($urandom_range(0, 3)), t, spd);
         end
      end
   endtask

   initial begin
      wait (!reset);
      // directed part, register reset values
      add_event(2'd3, TopTime, 16'hFFFF);              // sensor three is ignored
      add_event(2'd0, 64'd0, 16'd0);                   // same as stored time: held off
      add_event(2'd0, 64'd20000000, 16'd0);            // exactly the lockout: held off
      add_event(2'd0, 64'd20000001, 16'd0);            // just past lockout, no partner
      add_event(2'd1, 64'd20200001, 16'hFFFF);         // partner at window edge: counted
      add_event(2'd2, 64'd20200002, 16'd100);          // inside the hold-off
      add_event(2'd1, 64'd5, 16'd0);                   // time went backwards
      add_event(2'd0, TopTime - 64'd99, 16'd0);
      add_event(2'd1, TopTime - 64'd49, 16'hFFFF);     // counted near the top of time
      add_event(2'd2, TopTime - 64'd39, 16'hFFFF);     // hold-off end wraps: counted
      add_event(2'd2, TopTime - 64'd38, 16'hFFFF);     // bounce
      add_event(2'd0, 64'd30, 16'h8000);               // window wraps, held by the wrapped hold-off
      add_event(2'd3, rand64(), SpeedW'($urandom));
      drain();

      set_registers(DelayNumReset, VoteWinReset, VoteRstReset);
      run_strips(170, 64'd0);
      drain();
      set_registers('1, '0, '0);
      run_strips(170, rand64());
      drain();

      send_idle_pct = 46;
      recv_stall_pct = 20;
      set_registers('0, '1, '1);
      run_strips(170, TopTime - 64'd40000000000);
      drain();
      set_registers({8'($urandom), 32'($urandom)}, $urandom_range(0, 2000000),
                    $urandom_range(0, 20000000));
      run_strips(170, rand64());
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_registers(40'd1, 32'd1, 32'd1);
      run_strips(170, 64'd0);
      drain();
      set_registers({8'($urandom), 32'($urandom)}, $urandom, $urandom_range(0, 5000000));
      run_strips(170, rand64());
      drain();

      if (mismatches == 0 && predicted_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
